// ----- hdl/lsb_pkg.sv -----
// Shared widths, types and register codes for the seam blender.
package lsb_pkg;

  localparam int COLUMN_BITS   = 12;
  localparam int WIDTH_BITS    = COLUMN_BITS + 1;
  localparam int PIX_BITS      = 8;
  localparam int NUM_CH        = 3;
  localparam int QUOT_BITS     = PIX_BITS;
  localparam int NUM_BITS      = COLUMN_BITS + PIX_BITS;
  localparam int IN_RAW_BITS   = COLUMN_BITS + 2 * NUM_CH * PIX_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = NUM_CH * PIX_BITS;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_OVERLAP_START = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_WIDTH   = CFG_INDEX_BITS'(1);

  localparam logic [WIDTH_BITS-1:0] FIRST_WIDTH_RESET = WIDTH_BITS'(1) << COLUMN_BITS;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef pix_t [NUM_CH-1:0]   rgb_t;

  typedef struct packed {
    logic                            valid;
    logic                            bypass;
    rgb_t                            pix;
    logic [NUM_BITS-1:0]             dsh;
    logic [NUM_CH-1:0][NUM_BITS-1:0] rem;
    rgb_t                            quot;
  } lsb_cell_t;

endpackage

// ----- hdl/lsb_front.sv -----
// Front end: region decode, weight products and numerator sum, three stages.
module lsb_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lsb_pkg::COLUMN_BITS-1:0]     overlap_start,
  input  logic [lsb_pkg::WIDTH_BITS-1:0]      first_width,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lsb_pkg::COLUMN_BITS-1:0]     in_col,
  input  lsb_pkg::rgb_t                       in_a,
  input  lsb_pkg::rgb_t                       in_b,
  input  logic                                adv,
  output lsb_pkg::lsb_cell_t                  dout
);
  import lsb_pkg::*;

  logic                   v1, v2;
  logic                   byp1, byp2;
  rgb_t                   pix1, pix2;
  rgb_t                   a1, b1;
  logic [COLUMN_BITS-1:0] k1;
  logic [WIDTH_BITS-1:0]  w1, w2;
  logic [NUM_CH-1:0][NUM_BITS-1:0] pa2, pb2;
  lsb_cell_t              s3;

  logic en1, en2, en3;
  logic left, right, black;
  logic [WIDTH_BITS-1:0] wk;
  logic [NUM_CH-1:0][NUM_BITS-1:0] pa_next, pb_next;
  logic [PIX_BITS+WIDTH_BITS-1:0] prod_a [NUM_CH];
  logic [PIX_BITS+WIDTH_BITS-1:0] prod_b [NUM_CH];

  assign en3      = !s3.valid || adv;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign left  = in_col < overlap_start;
  assign right = {1'b0, in_col} >= first_width;
  assign black = (in_b == '0);

  assign wk = w1 - {1'b0, k1};

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod_a[i]  = (PIX_BITS+WIDTH_BITS)'(a1[i]) * (PIX_BITS+WIDTH_BITS)'(wk);
      prod_b[i]  = (PIX_BITS+WIDTH_BITS)'(b1[i]) * (PIX_BITS+WIDTH_BITS)'(k1);
      pa_next[i] = prod_a[i][NUM_BITS-1:0];
      pb_next[i] = prod_b[i][NUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      s3.valid <= 1'b0;
    end else begin
      if (en1) begin
        v1   <= in_valid;
        byp1 <= left || right || black;
        pix1 <= (!left && right) ? in_b : in_a;
        a1   <= in_a;
        b1   <= in_b;
        k1   <= in_col - overlap_start;
        w1   <= first_width - {1'b0, overlap_start};
      end
      if (en2) begin
        v2   <= v1;
        byp2 <= byp1;
        pix2 <= pix1;
        w2   <= w1;
        pa2  <= pa_next;
        pb2  <= pb_next;
      end
      if (en3) begin
        s3.valid  <= v2;
        s3.bypass <= byp2;
        s3.pix    <= pix2;
        s3.dsh    <= NUM_BITS'(w2) << (QUOT_BITS - 1);
        s3.quot   <= '0;
        for (int i = 0; i < NUM_CH; i++) begin
          s3.rem[i] <= pa2[i] + pb2[i];
        end
      end
    end
  end

  assign dout = s3;

endmodule

// ----- hdl/lsb_div_cell.sv -----
// One restoring-division cell: one quotient bit per channel, divisor shifts on.
module lsb_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  lsb_pkg::lsb_cell_t din,
  output logic               take,
  input  logic               adv,
  output lsb_pkg::lsb_cell_t dout
);
  import lsb_pkg::*;

  lsb_cell_t dout_next;
  logic      ge [NUM_CH];

  assign take = !dout.valid || adv;

  always_comb begin
    dout_next     = din;
    dout_next.dsh = din.dsh >> 1;
    for (int i = 0; i < NUM_CH; i++) begin
      ge[i] = din.rem[i] >= din.dsh;
      dout_next.rem[i]  = ge[i] ? din.rem[i] - din.dsh : din.rem[i];
      dout_next.quot[i] = {din.quot[i][PIX_BITS-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (take) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- hdl/linear_seam_blend.sv -----
// Top level of the seam blender: config registers, front end and divider chain.
//
// Blends two three-channel pixels across the overlap of two images.
// Input stream s_*: one transfer per pixel, column index plus both pixels.
// Output stream m_*: one transfer per input, the composite pixel, in order.
// Config channel cfg_*: index 0 sets overlap_start, index 1 sets first_width;
// always ready; the user must write only while no pixel is in flight, unchecked.
// Left of overlap_start the first pixel passes, at or beyond first_width the
// second pixel passes, a black second pixel inside the overlap gives the first.
// Otherwise each channel is floor((a*(W-k)+b*k)/W) with k = column-start.
// Pipeline: three front stages (decode, products, sum) and eight divider
// cells, one quotient bit each. One pixel per cycle while m_tready is high.
// When m_tready is low the chain fills its empty stages, then s_tready drops.
// Reset empties the pipeline and sets overlap_start to 0, first_width to 4096.
module linear_seam_blend (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lsb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [lsb_pkg::WIDTH_BITS-1:0]        cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // column, first_c0, first_c1, first_c2, second_c0, second_c1, second_c2, zero pad
  input  logic [lsb_pkg::IN_DATA_BITS-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // out_c0, out_c1, out_c2
  output logic [lsb_pkg::OUT_DATA_BITS-1:0]     m_tdata
);
  import lsb_pkg::*;

  logic [COLUMN_BITS-1:0] overlap_start;
  logic [WIDTH_BITS-1:0]  first_width;

  logic [COLUMN_BITS-1:0] col;
  rgb_t                   a, b, res;
  lsb_cell_t              chain [QUOT_BITS+1];
  logic                   adv   [QUOT_BITS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_start <= '0;
      first_width   <= FIRST_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OVERLAP_START: overlap_start <= cfg_data[COLUMN_BITS-1:0];
        REG_FIRST_WIDTH:   first_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign col = s_tdata[COLUMN_BITS-1:0];
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      a[i] = s_tdata[COLUMN_BITS + i*PIX_BITS +: PIX_BITS];
      b[i] = s_tdata[COLUMN_BITS + (NUM_CH+i)*PIX_BITS +: PIX_BITS];
    end
  end

  lsb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .overlap_start (overlap_start),
    .first_width   (first_width),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_col        (col),
    .in_a          (a),
    .in_b          (b),
    .adv           (adv[0]),
    .dout          (chain[0])
  );

  for (genvar g = 0; g < QUOT_BITS; g++) begin : g_cell
    lsb_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .take (adv[g]),
      .adv  (adv[g+1]),
      .dout (chain[g+1])
    );
  end

  assign adv[QUOT_BITS] = m_tready;

  assign m_tvalid = chain[QUOT_BITS].valid;
  assign res      = chain[QUOT_BITS].bypass ? chain[QUOT_BITS].pix : chain[QUOT_BITS].quot;
  assign m_tdata  = res;

endmodule
